[hdl/spcm_pkg.sv]
// Package for the servo pulse count mapper: widths, codes, reciprocal constants,
// the configuration bundle type and the microsecond to count conversion.
// No dependencies.
`default_nettype none

package spcm_pkg;

  // field widths
  localparam int MODE_W      = 2;
  localparam int CHAN_W      = 4;
  localparam int VALUE_W     = 12;
  localparam int COUNT_W     = 12;
  localparam int US_W        = 14;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 14;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_LEFT  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_RIGHT = 1'b1;

  // command modes, the unused code falls back to the raw clamp
  localparam logic [MODE_W-1:0] MODE_RAW   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POS   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ANGLE = 2'd2;

  // reset and default pulse widths in microseconds
  localparam logic [US_W-1:0] LEFT_US_RESET  = 14'd1000;
  localparam logic [US_W-1:0] RIGHT_US_RESET = 14'd2000;
  localparam int CENTER_PULSE_US_DEF = 1500;

  // position and angle landmarks
  localparam logic [VALUE_W-1:0] POS_MAX    = 12'd255;
  localparam logic [VALUE_W-1:0] POS_MID    = 12'd128;
  localparam logic [VALUE_W-1:0] ANGLE_MID  = 12'd90;
  localparam logic [VALUE_W-1:0] ANGLE_FULL = 12'd180;

  // reciprocal multiplication: floor(x / d) = (x * M) >> RECIP_SHIFT for the ranges used
  localparam int RECIP_SHIFT = 32;
  localparam longint unsigned M_US  = ((64'd1 << RECIP_SHIFT) + 64'd624) / 64'd625;
  localparam longint unsigned M_POS = ((64'd1 << RECIP_SHIFT) + 64'd509) / 64'd510;
  localparam longint unsigned M_ANG = ((64'd1 << RECIP_SHIFT) + 64'd179) / 64'd180;
  localparam int MUL_W = 25;

  // bias keeps the rounded quotient numerator non-negative
  localparam int POS_BIAS = 4096;
  localparam int ANG_BIAS = 8192;
  localparam longint unsigned K_POS_L = longint'(255 + 510 * POS_BIAS) * M_POS;
  localparam longint unsigned K_ANG_L = longint'(90 + 180 * ANG_BIAS) * M_ANG;

  // datapath widths of the scaling unit
  localparam int P_W    = 39;
  localparam int PROD_W = 48;
  localparam int SUM_W  = 49;
  localparam int QUOT_W = 15;
  localparam int Q_W    = 14;
  localparam int R_W    = 15;

  // scaling unit selection
  typedef enum logic [1:0] {
    SCALE_POS,
    SCALE_LOW,
    SCALE_HIGH
  } scale_sel_t;

  // end counts and per-segment slopes premultiplied by the reciprocal
  typedef struct packed {
    logic [COUNT_W-1:0]   lc;
    logic [COUNT_W-1:0]   rc;
    logic [COUNT_W-1:0]   cc;
    logic signed [P_W-1:0] p_pos;
    logic signed [P_W-1:0] p_lo;
    logic signed [P_W-1:0] p_hi;
  } cfg_t;

  // round(us * 204.8 / 1000) half up, as floor((us * 128 + 312) / 625)
  function automatic logic [COUNT_W-1:0] us_to_count(input logic [US_W-1:0] us);
    logic [21:0] y;
    logic [44:0] prod;
    y    = {1'b0, us, 7'b0} + 22'd312;
    prod = 45'(y) * 45'(M_US);
    return prod[RECIP_SHIFT +: COUNT_W];
  endfunction

endpackage

`default_nettype wire

[hdl/servo_pulse_count_mapper.sv]
// Top level of the servo pulse count mapper: request register, mode selection,
// saturation and result register. Depends on spcm_pkg, spcm_cfg and spcm_scale.
//
//   channel   direction  handshake            payload
//   request   in         start, busy          mode, channel, value
//   result    out        done (one cycle)     out_channel, pulse_count
//   config    in         cfg_we               cfg_index, cfg_data
//
// One request per cycle; its result passes the request register, then the result register.
// The path between request and result registers is one 9 x 39 multiply, a few adds
// and the saturation.
// Reset is synchronous; busy follows rst, so nothing is accepted during reset.
// A configuration write is used by a request accepted on the next edge or later.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module servo_pulse_count_mapper #(
  parameter int CENTER_PULSE_US = spcm_pkg::CENTER_PULSE_US_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [spcm_pkg::MODE_W-1:0]       mode,
  input  wire logic [spcm_pkg::CHAN_W-1:0]       channel,
  input  wire logic [spcm_pkg::VALUE_W-1:0]      value,
  output logic                                   done,
  output logic [spcm_pkg::CHAN_W-1:0]            out_channel,
  output logic [spcm_pkg::COUNT_W-1:0]           pulse_count,
  input  wire logic                              cfg_we,
  input  wire logic [spcm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [spcm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  spcm_pkg::cfg_t       cfg;
  spcm_pkg::scale_sel_t sel;

  logic                            accept;
  logic                            in_valid;
  logic [spcm_pkg::MODE_W-1:0]     in_mode;
  logic [spcm_pkg::CHAN_W-1:0]     in_channel;
  logic [spcm_pkg::VALUE_W-1:0]    in_value;

  logic [7:0]                      pos;
  logic [7:0]                      n_sc;
  logic signed [spcm_pkg::Q_W-1:0] q;
  logic signed [spcm_pkg::R_W-1:0] q_ext;
  logic signed [spcm_pkg::R_W-1:0] lc_s;
  logic signed [spcm_pkg::R_W-1:0] rc_s;
  logic signed [spcm_pkg::R_W-1:0] cc_s;
  logic signed [spcm_pkg::R_W-1:0] r;
  logic [spcm_pkg::COUNT_W-1:0]    count_next;

  assign busy   = rst;
  assign accept = start && !busy;

  spcm_cfg #(
    .CENTER_PULSE_US(CENTER_PULSE_US)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_mode    <= mode;
      in_channel <= channel;
      in_value   <= value;
    end
  end

  // position saturates at full scale
  assign pos = (in_value > spcm_pkg::POS_MAX) ? 8'hFF : in_value[7:0];

  // segment for the scaling unit
  always_comb begin
    if (in_mode == spcm_pkg::MODE_POS) begin
      sel  = spcm_pkg::SCALE_POS;
      n_sc = pos;
    end else if (in_value < spcm_pkg::ANGLE_MID) begin
      sel  = spcm_pkg::SCALE_LOW;
      n_sc = in_value[7:0];
    end else begin
      sel  = spcm_pkg::SCALE_HIGH;
      n_sc = in_value[7:0];
    end
  end

  spcm_scale u_scale (
    .n  (n_sc),
    .sel(sel),
    .cfg(cfg),
    .q  (q)
  );

  // mode selection
  always_comb begin
    q_ext = {q[spcm_pkg::Q_W-1], q};
    lc_s  = $signed({3'b0, cfg.lc});
    rc_s  = $signed({3'b0, cfg.rc});
    cc_s  = $signed({3'b0, cfg.cc});
    unique case (in_mode)
      spcm_pkg::MODE_POS: begin
        priority if ({4'b0, pos} == 12'd0)               r = lc_s;
        else if ({4'b0, pos} == spcm_pkg::POS_MID)      r = cc_s;
        else if ({4'b0, pos} == spcm_pkg::POS_MAX)      r = rc_s;
        else                                            r = lc_s + q_ext;
      end
      spcm_pkg::MODE_ANGLE: begin
        priority if (in_value == 12'd0)                 r = lc_s;
        else if (in_value == spcm_pkg::ANGLE_MID)       r = cc_s;
        else if (in_value >= spcm_pkg::ANGLE_FULL)      r = rc_s;
        else if (in_value < spcm_pkg::ANGLE_MID)        r = lc_s + q_ext;
        else                                            r = (cc_s <<< 1) - rc_s + q_ext;
      end
      default: begin
        // raw clamp, upper bound tested first
        priority if (in_value > cfg.rc)                 r = rc_s;
        else if (in_value < cfg.lc)                     r = lc_s;
        else                                            r = $signed({3'b0, in_value});
      end
    endcase
  end

  // saturate to the count range
  always_comb begin
    priority if (r[spcm_pkg::R_W-1])   count_next = '0;
    else if (r[spcm_pkg::R_W-2:spcm_pkg::COUNT_W] != '0) count_next = '1;
    else                                count_next = r[spcm_pkg::COUNT_W-1:0];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      out_channel <= in_channel;
      pulse_count <= count_next;
    end
  end

  // every accepted request gives a result through the request and result registers
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 done)
    else $error("accepted request gave no result");

  // no result without a request
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 2))
    else $error("result without a request");

  // channel travels with its request
  a_channel_kept: assert property (@(posedge clk) disable iff (rst)
    done |-> out_channel == $past(channel, 2))
    else $error("result channel differs from request channel");

endmodule

`default_nettype wire

[hdl/spcm_cfg.sv]
// Configuration registers of the servo pulse count mapper: end counts taken on write
// and slope products refreshed every cycle from them.
// Depends on spcm_pkg.
`default_nettype none

module spcm_cfg #(
  parameter int CENTER_PULSE_US = spcm_pkg::CENTER_PULSE_US_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [spcm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [spcm_pkg::CFG_DATA_W-1:0]    cfg_data,
  output spcm_pkg::cfg_t                          cfg
);

  localparam logic [spcm_pkg::COUNT_W-1:0] CC =
    spcm_pkg::us_to_count(spcm_pkg::US_W'(CENTER_PULSE_US));

  logic [spcm_pkg::COUNT_W-1:0] lc;
  logic [spcm_pkg::COUNT_W-1:0] rc;
  logic signed [spcm_pkg::P_W-1:0] p_pos;
  logic signed [spcm_pkg::P_W-1:0] p_lo;
  logic signed [spcm_pkg::P_W-1:0] p_hi;

  logic signed [13:0] d2_pos;
  logic signed [13:0] d2_lo;
  logic signed [13:0] d2_hi;
  logic signed [spcm_pkg::P_W:0] m_pos;
  logic signed [spcm_pkg::P_W:0] m_lo;
  logic signed [spcm_pkg::P_W:0] m_hi;

  // end counts, converted as they are written
  always_ff @(posedge clk) begin
    if (rst) begin
      lc <= spcm_pkg::us_to_count(spcm_pkg::LEFT_US_RESET);
      rc <= spcm_pkg::us_to_count(spcm_pkg::RIGHT_US_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        spcm_pkg::REG_LEFT:  lc <= spcm_pkg::us_to_count(cfg_data);
        spcm_pkg::REG_RIGHT: rc <= spcm_pkg::us_to_count(cfg_data);
      endcase
    end
  end

  // doubled segment spans, signed
  always_comb begin
    d2_pos = $signed(({2'b0, rc} - {2'b0, lc}) << 1);
    d2_lo  = $signed(({2'b0, CC} - {2'b0, lc}) << 1);
    d2_hi  = $signed(({2'b0, rc} - {2'b0, CC}) << 1);
    m_pos  = d2_pos * $signed({1'b0, spcm_pkg::MUL_W'(spcm_pkg::M_POS)});
    m_lo   = d2_lo * $signed({1'b0, spcm_pkg::MUL_W'(spcm_pkg::M_ANG)});
    m_hi   = d2_hi * $signed({1'b0, spcm_pkg::MUL_W'(spcm_pkg::M_ANG)});
  end

  // slope products are registered and follow the end counts in the cycle after
  always_ff @(posedge clk) begin
    p_pos <= m_pos[spcm_pkg::P_W-1:0];
    p_lo  <= m_lo[spcm_pkg::P_W-1:0];
    p_hi  <= m_hi[spcm_pkg::P_W-1:0];
  end

  assign cfg.lc    = lc;
  assign cfg.rc    = rc;
  assign cfg.cc    = CC;
  assign cfg.p_pos = p_pos;
  assign cfg.p_lo  = p_lo;
  assign cfg.p_hi  = p_hi;

endmodule

`default_nettype wire

[hdl/spcm_scale.sv]
// Rounded interpolation step of the servo pulse count mapper:
// round(span * n / den) by one multiply with a premultiplied slope.
// Depends on spcm_pkg.
`default_nettype none

module spcm_scale (
  input  wire logic                          [7:0] n,
  input  wire spcm_pkg::scale_sel_t                sel,
  input  wire spcm_pkg::cfg_t                      cfg,
  output logic signed [spcm_pkg::Q_W-1:0]          q
);

  logic signed [spcm_pkg::P_W-1:0]    p;
  logic [spcm_pkg::SUM_W-1:0]         k;
  logic [15:0]                        bias;
  logic signed [spcm_pkg::PROD_W-1:0] prod;
  logic [spcm_pkg::SUM_W-1:0]         sum;
  logic [spcm_pkg::QUOT_W-1:0]        quot;
  logic [15:0]                        diff;

  // slope, rounding offset and bias for the segment
  always_comb begin
    unique case (sel)
      spcm_pkg::SCALE_POS: begin
        p    = cfg.p_pos;
        k    = spcm_pkg::SUM_W'(spcm_pkg::K_POS_L);
        bias = 16'(spcm_pkg::POS_BIAS);
      end
      spcm_pkg::SCALE_LOW: begin
        p    = cfg.p_lo;
        k    = spcm_pkg::SUM_W'(spcm_pkg::K_ANG_L);
        bias = 16'(spcm_pkg::ANG_BIAS);
      end
      default: begin
        p    = cfg.p_hi;
        k    = spcm_pkg::SUM_W'(spcm_pkg::K_ANG_L);
        bias = 16'(spcm_pkg::ANG_BIAS);
      end
    endcase
  end

  // biased numerator times reciprocal, then drop the bias
  always_comb begin
    prod = $signed({1'b0, n}) * p;
    sum  = {prod[spcm_pkg::PROD_W-1], prod} + k;
    quot = sum[spcm_pkg::RECIP_SHIFT +: spcm_pkg::QUOT_W];
    diff = {1'b0, quot} - bias;
    q    = $signed(diff[spcm_pkg::Q_W-1:0]);
  end

endmodule

`default_nettype wire
